@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the line payload extractor.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define PLE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Next-cycle implication built on the macro above.
`define PLE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	`PLE_ASSERT(lbl, clk, rst_n, (ante) |=> (cons), msg)

`endif

@@ rtl/ple_pkg.sv @@
// Package: types, constants and helpers of the line payload extractor.
package ple_pkg;

	localparam int MAX_LEN    = 64;
	localparam int CNT_W      = (MAX_LEN > 2) ? $clog2(MAX_LEN) : 1;
	localparam int IDX_W      = 6;
	localparam int BYTE_W     = 8;
	localparam int PREFIX_LEN = 13;
	localparam int POS_W      = 4;

	localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(MAX_LEN - 1);
	localparam logic [POS_W-1:0]  POS_LAST = POS_W'(PREFIX_LEN - 1);
	localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0A;

	// Command codes of the input channel.
	localparam logic CMD_RX_BYTE = 1'b0;
	localparam logic CMD_CLEAR   = 1'b1;

	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_WAIT_LF = 2'd2
	} phase_t;

	typedef struct packed {
		logic              command;
		logic [BYTE_W-1:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic              payload_valid;
		logic [IDX_W-1:0]  payload_index;
		logic [BYTE_W-1:0] payload_byte;
		logic              message_done;
		logic [IDX_W-1:0]  message_length;
		logic              overflow;
		logic              ready_res;
	} result_t;

	// "+MQTTSUBRECV:"
	function automatic logic [BYTE_W-1:0] prefix_char(input logic [POS_W-1:0] pos);
		logic [BYTE_W-1:0] c;
		unique case (pos)
			4'd0:    c = 8'h2B; // +
			4'd1:    c = 8'h4D; // M
			4'd2:    c = 8'h51; // Q
			4'd3:    c = 8'h54; // T
			4'd4:    c = 8'h54; // T
			4'd5:    c = 8'h53; // S
			4'd6:    c = 8'h55; // U
			4'd7:    c = 8'h42; // B
			4'd8:    c = 8'h52; // R
			4'd9:    c = 8'h45; // E
			4'd10:   c = 8'h43; // C
			4'd11:   c = 8'h56; // V
			4'd12:   c = 8'h3A; // :
			default: c = 8'h2B;
		endcase
		return c;
	endfunction

	// Count to 6-bit index, masked or zero extended.
	function automatic logic [IDX_W-1:0] to_idx(input logic [CNT_W-1:0] cnt);
		logic [CNT_W+IDX_W-1:0] wide;
		wide = {{IDX_W{1'b0}}, cnt};
		return wide[IDX_W-1:0];
	endfunction

endpackage

@@ rtl/ple_if.sv @@
// Channel interfaces: input transactions and result transactions.
interface ple_in_if import ple_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output command, output rx_byte, input ready);
	modport sink   (input valid, input command, input rx_byte, output ready);
endinterface

interface ple_out_if import ple_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              payload_valid;
	logic [IDX_W-1:0]  payload_index;
	logic [BYTE_W-1:0] payload_byte;
	logic              message_done;
	logic [IDX_W-1:0]  message_length;
	logic              overflow;
	logic              ready_res;

	modport source (output valid, output payload_valid, output payload_index,
		output payload_byte, output message_done, output message_length,
		output overflow, output ready_res, input ready);
	modport sink   (input valid, input payload_valid, input payload_index,
		input payload_byte, input message_done, input message_length,
		input overflow, input ready_res, output ready);
endinterface

@@ rtl/prefixed_line_payload_extractor.sv @@
// Top level: prefixed line payload extractor with input and result registers.
//
// Usage:
//  in_ch  carries one transaction per received serial byte (command 0) or a
//         clear command (command 1) that drops the message-waiting flag.
//  out_ch returns exactly one result transaction per input transaction, in
//         order: payload byte with its index, message completion with length,
//         overflow status and the current ready flag.
//  The tracker hunts for "+MQTTSUBRECV:" only while no message is waiting,
//  then forwards bytes up to CR and completes the message on LF.
//
// Timing:
//  The accepting edge loads the input register; once the result register is
//  free or draining, the tracker runs and loads it. Without receiver stalls,
//  throughput is one transaction per cycle; the tracker updates its state in
//  the same cycle that it produces a result, so consecutive bytes chain.
//  When the receiver stalls, the result register holds, the input register
//  still takes one more transaction, and in_ch.ready drops once both are full.
// Reset (arst_n low): both registers empty, tracker back to prefix hunt with
// count, ready flag and overflow cleared.
`include "assert_macros.svh"

module prefixed_line_payload_extractor import ple_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	ple_in_if.sink    in_ch,
	ple_out_if.source out_ch
);

	item_t   item_s1;
	logic    vld_s1;
	result_t res_s2;
	logic    vld_s2;
	result_t res_d;
	logic    adv_s1;
	logic    in_acc;

	// Stage 1 moves forward when the result register is free or drains now.
	assign adv_s1      = vld_s1 && (!vld_s2 || out_ch.ready);
	assign in_ch.ready = !vld_s1 || adv_s1;
	assign in_acc      = in_ch.valid && in_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_acc) begin
			vld_s1 <= 1'b1;
		end else if (adv_s1) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1.command <= in_ch.command;
			item_s1.rx_byte <= in_ch.rx_byte;
		end
	end

	// State only advances for a transaction that leaves stage 1.
	ple_tracker u_tracker (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv_s1),
		.item   (item_s1),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s1) begin
			vld_s2 <= 1'b1;
		end else if (out_ch.ready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign out_ch.valid          = vld_s2;
	assign out_ch.payload_valid  = res_s2.payload_valid;
	assign out_ch.payload_index  = res_s2.payload_index;
	assign out_ch.payload_byte   = res_s2.payload_byte;
	assign out_ch.message_done   = res_s2.message_done;
	assign out_ch.message_length = res_s2.message_length;
	assign out_ch.overflow       = res_s2.overflow;
	assign out_ch.ready_res      = res_s2.ready_res;

	// A byte is either payload or a line end, never both.
	`PLE_ASSERT(a_done_excl, clk, arst_n, vld_s2 |-> !(res_s2.payload_valid && res_s2.message_done), "payload and done together")
	// A completed message always leaves the ready flag set.
	`PLE_ASSERT(a_done_rdy, clk, arst_n, (vld_s2 && res_s2.message_done) |-> res_s2.ready_res, "done without ready flag")
	// Bytes are only stored while the message has not overflowed.
	`PLE_ASSERT(a_store_ovf, clk, arst_n, (vld_s2 && res_s2.payload_valid) |-> !res_s2.overflow, "payload stored after overflow")
	// A stalled pipeline keeps its waiting transaction.
	`PLE_ASSERT_NEXT(a_hold_s1, clk, arst_n, vld_s1 && vld_s2 && !out_ch.ready, vld_s1, "stage 1 lost under stall")

endmodule

@@ rtl/ple_tracker.sv @@
// Message tracker: prefix hunt, payload counting and line completion state.
module ple_tracker import ple_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  item_t   item,
	output result_t res
);

	phase_t           ph_q, ph_d;
	logic [POS_W-1:0] pos_q, pos_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             rdy_q, rdy_d;
	logic             ovf_q, ovf_d;

	logic [POS_W-1:0] pos_eff;
	logic             is_cr;
	logic             is_lf;
	logic             has_room;
	logic             store;
	logic             done;

	assign pos_eff  = (pos_q > POS_LAST) ? '0 : pos_q;
	assign is_cr    = (item.rx_byte == CHAR_CR);
	assign is_lf    = (item.rx_byte == CHAR_LF);
	assign has_room = (cnt_q < CNT_LAST);

	// Next state
	always_comb begin
		ph_d  = ph_q;
		pos_d = pos_q;
		cnt_d = cnt_q;
		rdy_d = rdy_q;
		ovf_d = ovf_q;
		if (item.command == CMD_CLEAR) begin
			rdy_d = 1'b0;
		end else begin
			unique case (ph_q)
				PH_PAYLOAD: begin
					if (is_cr) begin
						ph_d = PH_WAIT_LF;
					end else if (has_room) begin
						cnt_d = cnt_q + 1'b1;
					end else begin
						ovf_d = 1'b1;
					end
				end
				PH_WAIT_LF: begin
					if (is_lf) begin
						rdy_d = 1'b1;
						ph_d  = PH_HUNT;
						pos_d = '0;
					end
				end
				default: begin
					ph_d = PH_HUNT;
					if (rdy_q) begin
						pos_d = '0;
					end else if (item.rx_byte == prefix_char(pos_eff)) begin
						if (pos_eff == POS_LAST) begin
							ph_d  = PH_PAYLOAD;
							pos_d = '0;
							cnt_d = '0;
							ovf_d = 1'b0;
						end else begin
							pos_d = pos_eff + 1'b1;
						end
					end else begin
						pos_d = (item.rx_byte == prefix_char('0)) ? POS_W'(1) : '0;
					end
				end
			endcase
		end
	end

	// Outputs
	always_comb begin
		store = (item.command == CMD_RX_BYTE) && (ph_q == PH_PAYLOAD) && !is_cr && has_room;
		done  = (item.command == CMD_RX_BYTE) && (ph_q == PH_WAIT_LF) && is_lf;
		res.payload_valid  = store;
		res.payload_index  = store ? to_idx(cnt_q) : '0;
		res.payload_byte   = store ? item.rx_byte : '0;
		res.message_done   = done;
		res.message_length = done ? to_idx(cnt_q) : '0;
		res.overflow       = ovf_d;
		res.ready_res      = rdy_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_HUNT;
			pos_q <= '0;
			cnt_q <= '0;
			rdy_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (en) begin
			ph_q  <= ph_d;
			pos_q <= pos_d;
			cnt_q <= cnt_d;
			rdy_q <= rdy_d;
			ovf_q <= ovf_d;
		end
	end

endmodule

@@ tb/sv/ple_result_checker.sv @@
// Result checker: predicts every result from the accepted input transactions and compares in order.
module ple_result_checker (
	input  logic clk,
	input  logic arst_n,
	ple_in_if    in_ch,
	ple_out_if   out_ch,
	output int   mismatch_count,
	output int   results_pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import ple_pkg::*;

	localparam logic [8*PREFIX_LEN-1:0] MQTT_PREFIX = "+MQTTSUBRECV:";

	// Tracker state as the predictor sees it.
	phase_t           trk_phase;
	logic [POS_W-1:0] trk_pos;
	int               trk_count;
	logic             msg_waiting;
	logic             trk_overflow;

	result_t expected_results[$];

	function automatic logic [7:0] prefix_at(input logic [POS_W-1:0] p);
		return MQTT_PREFIX[8*(PREFIX_LEN-1-int'(p)) +: 8];
	endfunction

	// One input transaction in, one predicted result out; updates the tracker.
	function automatic result_t extract_result(input logic cmd, input logic [7:0] b);
		result_t r;
		r = '0;
		if (cmd == CMD_CLEAR) begin
			msg_waiting = 1'b0;
		end else begin
			case (trk_phase)
				PH_PAYLOAD: begin
					if (b == CHAR_CR) begin
						trk_phase = PH_WAIT_LF;
					end else if (trk_count < MAX_LEN - 1) begin
						r.payload_valid = 1'b1;
						r.payload_index = IDX_W'(trk_count);
						r.payload_byte  = b;
						trk_count++;
					end else begin
						trk_overflow = 1'b1;
					end
				end
				PH_WAIT_LF: begin
					if (b == CHAR_LF) begin
						r.message_done   = 1'b1;
						r.message_length = IDX_W'(trk_count);
						msg_waiting      = 1'b1;
						trk_phase        = PH_HUNT;
						trk_pos          = '0;
					end
				end
				default: begin
					trk_phase = PH_HUNT;
					if (msg_waiting) begin
						trk_pos = '0;
					end else if (b == prefix_at(trk_pos)) begin
						if (trk_pos == POS_LAST) begin
							trk_phase    = PH_PAYLOAD;
							trk_pos      = '0;
							trk_count    = 0;
							trk_overflow = 1'b0;
						end else begin
							trk_pos++;
						end
					end else begin
						// restart; a '+' already counts as the first character
						trk_pos = (b == prefix_at('0)) ? POS_W'(1) : '0;
					end
				end
			endcase
		end
		r.overflow  = trk_overflow;
		r.ready_res = msg_waiting;
		return r;
	endfunction

	task automatic check_field(input string field, input logic [7:0] expv,
			input logic [7:0] actv);
		if (expv !== actv) begin
			$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
				$time, field, expv, actv);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			trk_phase    = PH_HUNT;
			trk_pos      = '0;
			trk_count    = 0;
			msg_waiting  = 1'b0;
			trk_overflow = 1'b0;
			expected_results.delete();
			results_pending = 0;
			mismatch_count  = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: result transaction with none expected, expected none, actual %0h",
						$time, {out_ch.payload_valid, out_ch.payload_index,
						out_ch.payload_byte, out_ch.message_done, out_ch.message_length,
						out_ch.overflow, out_ch.ready_res});
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("payload_valid",  want.payload_valid,  out_ch.payload_valid);
					check_field("payload_index",  want.payload_index,  out_ch.payload_index);
					check_field("payload_byte",   want.payload_byte,   out_ch.payload_byte);
					check_field("message_done",   want.message_done,   out_ch.message_done);
					check_field("message_length", want.message_length, out_ch.message_length);
					check_field("overflow",       want.overflow,       out_ch.overflow);
					check_field("ready_res",      want.ready_res,      out_ch.ready_res);
				end
			end
			if (in_ch.valid && in_ch.ready)
				expected_results.push_back(extract_result(in_ch.command, in_ch.rx_byte));
			results_pending = expected_results.size();
		end
	end

endmodule

@@ tb/sv/tb_prefixed_line_payload_extractor.sv @@
// Testbench top: drives byte and clear transactions, paces the result side, gives the verdict.
module tb_prefixed_line_payload_extractor;
	timeunit 1ns;
	timeprecision 1ps;
	import ple_pkg::*;

	localparam logic [8*PREFIX_LEN-1:0] MQTT_PREFIX = "+MQTTSUBRECV:";
	localparam int RANDOM_ITEMS    = 1250;
	localparam int WATCHDOG_LIMIT  = 2000; // far above the long hold-off below
	localparam int HOLD_OFF_CYCLES = 200;
	localparam int DRAIN_CYCLES    = 10;   // longer than the block's input-to-result latency

	logic clk = 1'b0;
	logic arst_n;

	int   send_idle_pct;   // chance in 100 that the sender idles a cycle
	int   recv_stall_pct;  // chance in 100 that the receiver stalls a cycle
	bit   hold_req;        // asks the receiver for one long hold-off
	int   items_sent;
	int   idle_cycles;
	int   mismatch_count;
	int   results_pending;

	ple_in_if  in_ch();
	ple_out_if out_ch();

	prefixed_line_payload_extractor u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	ple_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_ch           (in_ch),
		.out_ch          (out_ch),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Receiver pacing. A hold-off request keeps ready low for a long stretch,
	// counted here, while the sender keeps offering; the block's two registers
	// fill and in_ch.ready must drop.
	always begin
		@(posedge clk);
		if (hold_req) begin
			out_ch.ready <= 1'b0;
			repeat (HOLD_OFF_CYCLES) @(posedge clk);
			hold_req = 1'b0;
		end
		out_ch.ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: cycles in a row with no transaction on either channel.
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offers one transaction and returns at the edge that accepts it. valid is
	// left high so back-to-back transactions need no extra assignment. Ready is
	// looked at on the falling edge, where nothing is changing.
	task automatic send_item(input logic cmd, input logic [7:0] b);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid   <= 1'b1;
		in_ch.command <= cmd;
		in_ch.rx_byte <= b;
		@(negedge clk);
		while (!in_ch.ready) @(negedge clk);
		@(posedge clk);
		items_sent++;
	endtask

	// Sender pauses until every predicted result has been checked.
	task automatic drain_results();
		in_ch.valid <= 1'b0;
		@(negedge clk);
		while (results_pending != 0) @(negedge clk);
		@(posedge clk);
	endtask

	// Prefix, optionally with one wrong character at break_at (-1: intact).
	task automatic send_prefix(input int break_at);
		logic [7:0] c;
		for (int i = 0; i < PREFIX_LEN; i++) begin
			c = MQTT_PREFIX[8*(PREFIX_LEN-1-i) +: 8];
			if (i == break_at) begin
				if ($urandom_range(1) == 0 && i != 0)
					c = MQTT_PREFIX[8*(PREFIX_LEN-1) +: 8]; // '+' restarts the match
				else
					c = c ^ 8'($urandom_range(1, 255));
			end
			send_item(CMD_RX_BYTE, c);
		end
	endtask

	// Whole line: prefix, payload without CR, CR, optional junk, LF.
	task automatic send_message(input int len, input int break_at, input int junk);
		logic [7:0] b;
		send_prefix(break_at);
		repeat (len) begin
			b = 8'($urandom_range(255));
			while (b == CHAR_CR) b = 8'($urandom_range(255));
			send_item(CMD_RX_BYTE, b);
		end
		send_item(CMD_RX_BYTE, CHAR_CR);
		repeat (junk) begin
			b = 8'($urandom_range(255));
			while (b == CHAR_LF) b = 8'($urandom_range(255));
			send_item(CMD_RX_BYTE, b);
		end
		send_item(CMD_RX_BYTE, CHAR_LF);
	endtask

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(7))
			0:       return CHAR_CR;
			1:       return CHAR_LF;
			2:       return MQTT_PREFIX[8*(PREFIX_LEN-1) +: 8];
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Mostly well-formed lines with random content and lengths; some with a
	// broken prefix, some left unconsumed so the next line hits a waiting
	// message; the rest stray bytes and clears.
	task automatic random_sequence();
		int kind;
		int len;
		int sel;
		kind = $urandom_range(99);
		if (kind < 75) begin
			sel = $urandom_range(99);
			if (sel < 8)
				len = $urandom_range(MAX_LEN - 4, MAX_LEN + 6); // around capacity
			else if (sel < 15)
				len = 0;
			else
				len = $urandom_range(1, 12);
			send_message(len,
				($urandom_range(99) < 10) ? $urandom_range(PREFIX_LEN - 1) : -1,
				($urandom_range(99) < 20) ? $urandom_range(1, 3) : 0);
			if ($urandom_range(99) < 85)
				send_item(CMD_CLEAR, 8'($urandom_range(255)));
		end else if (kind < 92) begin
			repeat ($urandom_range(1, 6))
				send_item(($urandom_range(99) < 15) ? CMD_CLEAR : CMD_RX_BYTE, noise_byte());
		end else begin
			send_item(CMD_CLEAR, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		int target;
		in_ch.valid   <= 1'b0;
		in_ch.command <= CMD_RX_BYTE;
		in_ch.rx_byte <= '0;
		out_ch.ready  <= 1'b0;
		arst_n        <= 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_req       = 1'b0;
		items_sent     = 0;
		idle_cycles    = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: clear with nothing waiting, "+M" then '+' restarting the
		// match, payload extremes and an LF inside the payload, junk while
		// waiting for LF, a prefix start ignored while the message waits,
		// then the clear that consumes it.
		send_item(CMD_CLEAR, 8'h00);
		send_item(CMD_RX_BYTE, MQTT_PREFIX[8*(PREFIX_LEN-1) +: 8]);
		send_item(CMD_RX_BYTE, MQTT_PREFIX[8*(PREFIX_LEN-2) +: 8]);
		send_prefix(-1);
		send_item(CMD_RX_BYTE, 8'h00);
		send_item(CMD_RX_BYTE, 8'hFF);
		send_item(CMD_RX_BYTE, CHAR_LF);
		send_item(CMD_RX_BYTE, CHAR_CR);
		send_item(CMD_RX_BYTE, 8'hFF);
		send_item(CMD_RX_BYTE, CHAR_LF);
		send_item(CMD_RX_BYTE, MQTT_PREFIX[8*(PREFIX_LEN-1) +: 8]);
		send_item(CMD_CLEAR, 8'hFF);
		drain_results();

		// Random phases: no idling (but the long hold-off), sender idle, receiver stalling, both.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 50; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 50; end
				default: begin send_idle_pct = 22; recv_stall_pct = 22; end
			endcase
			if (ph == 0)
				hold_req = 1'b1;
			target = items_sent + RANDOM_ITEMS / 4;
			while (items_sent < target) random_sequence();
			drain_results();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
